### hdl/uar_pkg.sv
// Shared types, constants and the digit-to-character function for the radix converter.
package uar_pkg;

	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned RADIX_BITS = 8;
	localparam int unsigned CHAR_BITS  = 8;

	localparam logic [CHAR_BITS-1:0] ASCII_ZERO    = 8'd48;
	localparam logic [CHAR_BITS-1:0] ASCII_LOWER_A = 8'd97;
	localparam logic [CHAR_BITS-1:0] DECIMAL_SPLIT = 8'd10;
	localparam logic [RADIX_BITS-1:0] MIN_RADIX    = 8'd2;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic [RADIX_BITS-1:0] radix;
	} num_t;

	typedef struct packed {
		logic [CHAR_BITS-1:0] digit_char;
		logic                 last;
		logic                 bad_radix;
	} dig_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV,
		S_STORE,
		S_READ,
		S_EMIT,
		S_ERR
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic div_step;
		logic store;
		logic rd;
		logic pop;
		logic show_err;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bad_in;
		logic div_done;
		logic quot_zero;
		logic last;
	} status_t;

	// Digits below ten map to '0'..'9', larger ones to 'a' onward, wrapping in a byte.
	function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [CHAR_BITS-1:0] d);
		logic [CHAR_BITS-1:0] c;
		if (d < DECIMAL_SPLIT) begin
			c = ASCII_ZERO + d;
		end else begin
			c = d + (ASCII_LOWER_A - DECIMAL_SPLIT);
		end
		return c;
	endfunction

endpackage

### hdl/uar_ctrl.sv
// Controller state machine that sequences division, digit storage and character output.
module uar_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            num_valid,
	output logic            num_ready,
	output logic            dig_valid,
	input  logic            dig_ready,
	output uar_pkg::cmd_t   cmd,
	input  uar_pkg::status_t st
);
	import uar_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		num_ready = 1'b0;
		dig_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				num_ready = 1'b1;
				if (num_valid) begin
					cmd.load = 1'b1;
					state_d  = st.bad_in ? S_ERR : S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_done) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				cmd.store = 1'b1;
				state_d   = st.quot_zero ? S_READ : S_DIV;
			end
			S_READ: begin
				cmd.rd  = 1'b1;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				dig_valid = 1'b1;
				if (dig_ready) begin
					cmd.pop = 1'b1;
					state_d = st.last ? S_IDLE : S_READ;
				end
			end
			S_ERR: begin
				dig_valid    = 1'b1;
				cmd.show_err = 1'b1;
				if (dig_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

### hdl/uar_dp.sv
// Datapath: bit-serial divider, digit store and output character register.
module uar_dp #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  uar_pkg::num_t    num,
	input  uar_pkg::cmd_t    cmd,
	output uar_pkg::status_t st,
	output uar_pkg::dig_t    dig
);
	import uar_pkg::*;

	localparam int unsigned AW = $clog2(VALUE_WIDTH);
	localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

	logic [VALUE_WIDTH-1:0] v_q;
	logic [RADIX_BITS-1:0]  r_q;
	logic [RADIX_BITS-1:0]  rem_q;
	logic [AW-1:0]          cnt_q;
	logic [CW-1:0]          ptr_q;
	logic [CHAR_BITS-1:0]   char_q;
	logic [CHAR_BITS-1:0]   mem [VALUE_WIDTH];

	logic [RADIX_BITS:0]    shifted;
	logic [RADIX_BITS:0]    diff;
	logic                   ge;
	logic [CW-1:0]          ptr_m1;
	logic [CHAR_BITS-1:0]   new_char;

	// One restoring step: bring down the next dividend bit and try to subtract the radix.
	assign shifted  = {rem_q, v_q[VALUE_WIDTH-1]};
	assign ge       = (shifted >= {1'b0, r_q});
	assign diff     = shifted - {1'b0, r_q};
	assign ptr_m1   = ptr_q - CW'(1);
	assign new_char = digit_to_char(rem_q);

	assign st.bad_in    = (num.radix < MIN_RADIX);
	assign st.div_done  = (cnt_q == AW'(VALUE_WIDTH - 1));
	assign st.quot_zero = (v_q == '0);
	assign st.last      = (ptr_q == CW'(1));

	assign dig.digit_char = cmd.show_err ? '0 : char_q;
	assign dig.last       = cmd.show_err ? 1'b1 : st.last;
	assign dig.bad_radix  = cmd.show_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				ptr_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + AW'(1);
			end else if (cmd.store) begin
				cnt_q <= '0;
				ptr_q <= ptr_q + CW'(1);
			end else if (cmd.pop) begin
				ptr_q <= ptr_m1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			v_q   <= VALUE_WIDTH'(num.value);
			r_q   <= num.radix;
			rem_q <= '0;
		end else if (cmd.div_step) begin
			v_q   <= {v_q[VALUE_WIDTH-2:0], ge};
			rem_q <= ge ? diff[RADIX_BITS-1:0] : shifted[RADIX_BITS-1:0];
		end else if (cmd.store) begin
			rem_q <= '0;
		end
	end

	// Digits arrive least significant first and are read back in reverse order.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			mem[ptr_q[AW-1:0]] <= new_char;
		end
		if (cmd.rd) begin
			char_q <= mem[ptr_m1[AW-1:0]];
		end
	end

endmodule

### hdl/unsigned_to_ascii_radix_core.sv
// Top level of the unsigned number to ASCII digit converter for any radix from 2 to 255.
// Sequencing: after a transaction is accepted, each digit takes one divider step per quotient bit
// followed by a store step.
// Output: each character is then read from the digit store and presented, and waits while the
// consumer stalls; a bad radix gives its single result in the cycle after acceptance.
// The block converts one number at a time and takes no new one until the last is fully output.
// Reset: arst_n idles the controller, clears step count and digit pointer, not the store or data.
module unsigned_to_ascii_radix_core #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          num_valid,
	output logic          num_ready,
	input  uar_pkg::num_t num,
	output logic          dig_valid,
	input  logic          dig_ready,
	output uar_pkg::dig_t dig
);
	import uar_pkg::*;

	// The controller and datapath exchange only these command and status groups.
	cmd_t    cmd;
	status_t st;

	// The controller accepts a number only when idle, runs one long division per digit,
	// and then walks the stored digits back out, most significant first.
	uar_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_ready (num_ready),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.cmd       (cmd),
		.st        (st)
	);

	// The datapath holds the running quotient, the remainder, the digit store and the
	// registered output character. A radix below two yields one flagged result.
	uar_dp #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num),
		.cmd    (cmd),
		.st     (st),
		.dig    (dig)
	);

endmodule

### hdl/uar_chk.sv
// Port-level assertion checker for the converter, bound to the top level.
module uar_chk (
	input logic          clk,
	input logic          arst_n,
	input logic          num_valid,
	input logic          num_ready,
	input uar_pkg::num_t num,
	input logic          dig_valid,
	input logic          dig_ready,
	input uar_pkg::dig_t dig
);
	import uar_pkg::*;

	// A stalled result transaction keeps its payload.
	a_dig_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && !dig_ready |=> dig_valid && $stable(dig))
		else $error("result changed while stalled");

	// An error result is a single character of value zero that closes the number.
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		dig_valid && dig.bad_radix |-> dig.last && (dig.digit_char == '0))
		else $error("malformed error result");

	// A number with a radix below two is answered by an error result in the next cycle.
	a_err_next: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready && (num.radix < MIN_RADIX) |=> dig_valid && dig.bad_radix)
		else $error("bad radix not flagged");

	// The block is busy right after taking a number.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		num_valid && num_ready |=> !num_ready)
		else $error("accepted a second number too early");

	// Results are offered only while no new number can be taken.
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		num_ready |-> !dig_valid)
		else $error("result offered while idle");

endmodule

bind unsigned_to_ascii_radix_core uar_chk u_chk (.*);

### tb/radix_digit_checker.sv
// Checker that predicts the ASCII digits of every accepted number and compares them with the output.
module radix_digit_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           num_valid,
	input  logic           num_ready,
	input  uar_pkg::num_t  num,
	input  logic           dig_valid,
	input  logic           dig_ready,
	input  uar_pkg::dig_t  dig,
	output int             errors,
	output int             outstanding,
	output int             numbers_seen,
	output int             bad_radix_seen,
	output int             chars_seen,
	output int             longest_number
);
	timeunit 1ns;
	timeprecision 1ps;
	import uar_pkg::*;

	// Characters still owed by the block, oldest first.
	dig_t chars_due[$];

	function automatic logic [CHAR_BITS-1:0] char_of(input logic [VALUE_BITS-1:0] d);
		if (d < DECIMAL_SPLIT) begin
			return 8'(ASCII_ZERO + d);
		end
		// Radices above 36 run past 'z'; digits from 169 up wrap within the byte.
		return 8'(d - DECIMAL_SPLIT + ASCII_LOWER_A);
	endfunction

	// Queues the characters that one number should produce.
	function automatic void spell_number(input num_t n);
		logic [VALUE_BITS-1:0] rest;
		logic [VALUE_BITS-1:0] base;
		logic [CHAR_BITS-1:0]  msd_first[$];
		dig_t                  d;
		if (n.radix < MIN_RADIX) begin
			d.digit_char = '0;
			d.last = 1'b1;
			d.bad_radix = 1'b1;
			chars_due.push_back(d);
			bad_radix_seen++;
			return;
		end
		rest = n.value;
		base = VALUE_BITS'(n.radix);
		do begin
			msd_first.push_front(char_of(rest % base));
			rest = rest / base;
		end while (rest != '0);
		foreach (msd_first[k]) begin
			d.digit_char = msd_first[k];
			d.last = (k == msd_first.size() - 1);
			d.bad_radix = 1'b0;
			chars_due.push_back(d);
		end
		if (msd_first.size() > longest_number) begin
			longest_number = msd_first.size();
		end
	endfunction

	task automatic flag(input string field, input logic [7:0] want, input logic [7:0] got);
		errors++;
		$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		dig_t want;
		if (!arst_n) begin
			chars_due.delete();
			errors = 0;
			numbers_seen = 0;
			bad_radix_seen = 0;
			chars_seen = 0;
			longest_number = 0;
		end else begin
			if (dig_valid && dig_ready) begin
				chars_seen++;
				if (chars_due.size() == 0) begin
					errors++;
					$display("%0t ns: unexpected character, expected none, actual %0h/%0b/%0b",
						$time, dig.digit_char, dig.last, dig.bad_radix);
				end else begin
					want = chars_due.pop_front();
					if (dig.digit_char !== want.digit_char) begin
						flag("digit_char", want.digit_char, dig.digit_char);
					end
					if (dig.last !== want.last) begin
						flag("last", 8'(want.last), 8'(dig.last));
					end
					if (dig.bad_radix !== want.bad_radix) begin
						flag("bad_radix", 8'(want.bad_radix), 8'(dig.bad_radix));
					end
				end
			end
			if (num_valid && num_ready) begin
				numbers_seen++;
				spell_number(num);
			end
		end
		outstanding = chars_due.size();
	end

endmodule

### tb/tb.sv
// Top-level testbench that drives numbers into the radix converter and reports the verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import uar_pkg::*;

	// The slowest number (radix 2, top bit set) needs 32 full divisions before its first
	// character appears, so a quiet stretch well beyond that is a hang.
	localparam int QUIET_LIMIT = 5000;
	localparam int IDLE_PCT    = 18;
	localparam int RANDOM_NUMS = 200;

	logic clk = 1'b0;
	logic arst_n;
	logic num_valid;
	logic num_ready;
	num_t num;
	logic dig_valid;
	logic dig_ready = 1'b0;
	dig_t dig;

	// While calm is set neither side inserts idle cycles.
	logic calm = 1'b0;
	int   quiet_cycles = 0;

	int errors;
	int outstanding;
	int numbers_seen;
	int bad_radix_seen;
	int chars_seen;
	int longest_number;

	unsigned_to_ascii_radix_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.num_valid(num_valid),
		.num_ready(num_ready),
		.num      (num),
		.dig_valid(dig_valid),
		.dig_ready(dig_ready),
		.dig      (dig)
	);

	radix_digit_checker check_digits (
		.clk           (clk),
		.arst_n        (arst_n),
		.num_valid     (num_valid),
		.num_ready     (num_ready),
		.num           (num),
		.dig_valid     (dig_valid),
		.dig_ready     (dig_ready),
		.dig           (dig),
		.errors        (errors),
		.outstanding   (outstanding),
		.numbers_seen  (numbers_seen),
		.bad_radix_seen(bad_radix_seen),
		.chars_seen    (chars_seen),
		.longest_number(longest_number)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// The character consumer stalls at random unless the calm stretch is running.
	always @(negedge clk) begin
		dig_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
	end

	// The watchdog counts cycles in which no transaction completes on either channel.
	always @(posedge clk) begin
		if (!arst_n || (num_valid && num_ready) || (dig_valid && dig_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t ns: no transaction for %0d cycles, giving up", $time, QUIET_LIMIT);
			$display("[unsigned_to_ascii_radix_core] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Presents one number at a falling edge and holds it until the transaction completes.
	// A random number of idle cycles goes ahead of it, so gaps land on every phase of the
	// conversion. The task returns at the falling edge after acceptance.
	task automatic send_number(input num_t item);
		int gap;
		gap = 0;
		if (!calm) begin
			while ($urandom_range(99) < IDLE_PCT) begin
				gap++;
			end
		end
		if (gap > 0) begin
			num_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num_valid <= 1'b1;
		num <= item;
		do begin
			@(posedge clk);
		end while (!num_ready);
		@(negedge clk);
	endtask

	initial begin
		num_t             plan[$];
		num_t             item;
		longint unsigned  power;
		int               pick;

		num_valid = 1'b0;
		num = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part: zero, the widest and narrowest spellings, the letter range,
		// the wrap past 'z' for large radices, and both radices that are rejected.
		plan.push_back('{value: 32'd0, radix: 8'd10});
		plan.push_back('{value: 32'd0, radix: 8'd2});
		plan.push_back('{value: 32'hFFFF_FFFF, radix: 8'd2});
		plan.push_back('{value: 32'h8000_0000, radix: 8'd2});
		plan.push_back('{value: 32'd1, radix: 8'd2});
		plan.push_back('{value: 32'hFFFF_FFFF, radix: 8'd10});
		plan.push_back('{value: 32'd10, radix: 8'd10});
		plan.push_back('{value: 32'hDEAD_BEEF, radix: 8'd16});
		plan.push_back('{value: 32'd35, radix: 8'd36});
		plan.push_back('{value: 32'd36, radix: 8'd37});
		plan.push_back('{value: 32'd254, radix: 8'd255});
		plan.push_back('{value: 32'hFFFF_FFFF, radix: 8'd255});
		plan.push_back('{value: 32'hAAAA_AAAA, radix: 8'd128});
		plan.push_back('{value: 32'h5555_5555, radix: 8'd3});
		plan.push_back('{value: 32'd12345, radix: 8'd0});
		plan.push_back('{value: 32'hFFFF_FFFF, radix: 8'd1});
		plan.push_back('{value: 32'd0, radix: 8'd0});
		plan.push_back('{value: 32'd0, radix: 8'd1});
		plan.push_back('{value: 32'd200, radix: 8'd200});
		plan.push_back('{value: 32'd65535, radix: 8'd254});
		foreach (plan[k]) begin
			send_number(plan[k]);
		end

		// Random part. Radix 2 is favored now and then because it gives the longest
		// conversions; values near a power of the radix move the digit count boundary.
		for (int k = 0; k < RANDOM_NUMS; k++) begin
			calm = (k >= 80) && (k < 130);
			pick = $urandom_range(99);
			if (pick < 8) begin
				item.radix = 8'($urandom_range(1, 0));
			end else if (pick < 18) begin
				item.radix = MIN_RADIX;
			end else if (pick < 45) begin
				item.radix = 8'($urandom_range(16, 2));
			end else begin
				item.radix = 8'($urandom_range(255, 2));
			end
			pick = $urandom_range(99);
			if (pick < 20) begin
				item.value = $urandom_range(400, 0);
			end else if (pick < 45 && item.radix >= MIN_RADIX) begin
				power = 1;
				repeat ($urandom_range(31, 1)) begin
					if (power * item.radix <= 64'hFFFF_FFFF) begin
						power = power * item.radix;
					end
				end
				item.value = 32'(power - $urandom_range(1, 0));
			end else begin
				item.value = $urandom;
			end
			send_number(item);
		end
		calm = 1'b0;
		num_valid <= 1'b0;

		// Drain the outstanding characters, then linger long enough for a stray extra
		// character to show up and be caught.
		while (outstanding != 0) begin
			@(negedge clk);
		end
		repeat (4 * VALUE_BITS) @(negedge clk);

		$display("Run covered %0d numbers, %0d of them with a rejected radix.",
			numbers_seen, bad_radix_seen);
		$display("It checked %0d characters; the longest number had %0d digits.",
			chars_seen, longest_number);
		if (errors == 0) begin
			$display("[unsigned_to_ascii_radix_core] OK");
		end else begin
			$display("[unsigned_to_ascii_radix_core] ERROR");
		end
		$finish;
	end

endmodule

### unsigned_to_ascii_radix_core.f
hdl/uar_pkg.sv
hdl/uar_ctrl.sv
hdl/uar_dp.sv
hdl/unsigned_to_ascii_radix_core.sv
hdl/uar_chk.sv
tb/radix_digit_checker.sv
tb/tb.sv
